// File: hdl/dlfr_pkg.sv
// shared types, constants and helper functions of the display link frame responder
package dlfr_pkg;

	localparam int unsigned CFG_AW = 2;
	localparam int unsigned CFG_DW = 32;

	localparam logic [CFG_AW-1:0] REG_START_BYTE = 2'd0;
	localparam logic [CFG_AW-1:0] REG_END_BYTE   = 2'd1;
	localparam logic [CFG_AW-1:0] REG_LEVEL_POS  = 2'd2;
	localparam logic [CFG_AW-1:0] REG_GEAR_RATIO = 2'd3;

	localparam logic [7:0]  RST_START_BYTE = 8'd58;
	localparam logic [7:0]  RST_END_BYTE   = 8'd13;
	localparam logic [2:0]  RST_LEVEL_POS  = 3'd1;
	localparam logic [31:0] RATIO_LOW      = 32'h0001_0001;
	localparam logic [31:0] RATIO_HIGH     = 32'h00F0_00F0;

	localparam int unsigned CURRENT_FULL_AMPS = 60;
	localparam logic [25:0] CUR_DIV    = 26'(32'h7FFF / CURRENT_FULL_AMPS);
	// reciprocal of the current divisor, exact for sums up to 65536, the largest sum of two magnitudes
	localparam int unsigned CUR_SHIFT  = 26;
	localparam logic [16:0] CUR_RECIP  = 17'((64'd1 << CUR_SHIFT) / 64'(CUR_DIV) + 64'd1);
	// speed times 500 over 60 reduces to speed times 25 over 3
	localparam logic [4:0]  SPEED_MUL  = 5'd25;
	localparam int unsigned SPEED_SHIFT = 30;
	localparam logic [28:0] SPEED_RECIP = 29'(((64'd1 << SPEED_SHIFT) + 64'd2) / 64'd3);
	localparam logic [31:0] PERIOD_NUM = 32'd500000;
	localparam logic [15:0] PERIOD_MAX = 16'hFFFF;
	localparam logic [7:0]  ERR_CODE   = 8'h00;
	localparam logic [7:0]  BRAKE_CODE = 8'h04;
	localparam logic [3:0]  REPLY_LAST = 4'd12;
	localparam logic [3:0]  FRAME_LAST = 4'd8;

	localparam int unsigned DIV_W   = 32;
	localparam int unsigned DIVR_W  = 26;

	typedef struct packed {
		logic        upd;
		logic [2:0]  lvl;
		logic [16:0] cur_sum;
		logic [16:0] spd_mag;
	} job_t;

	typedef struct packed {
		logic       upd;
		logic [2:0] lvl;
	} level_t;

	function automatic logic [16:0] mag16(input logic [15:0] v);
		logic [16:0] r;
		r = v[15] ? (17'h1_0000 - {1'b0, v}) : {1'b0, v};
		return r;
	endfunction

	function automatic level_t decode_level(input logic [3:0] code);
		level_t r;
		r = '0;
		unique case (code)
			4'd0: r = '{upd: 1'b1, lvl: 3'd0};
			4'd1: r = '{upd: 1'b1, lvl: 3'd1};
			4'd3: r = '{upd: 1'b1, lvl: 3'd2};
			4'd5: r = '{upd: 1'b1, lvl: 3'd3};
			4'd7: r = '{upd: 1'b1, lvl: 3'd4};
			4'd9: r = '{upd: 1'b1, lvl: 3'd5};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/dlfr_front.sv
// front end: telemetry latch, frame assembly, checksum check and job issue
module dlfr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic               req_type,
	input  logic [7:0]         rx_byte,
	input  logic [15:0]        current_motor_a,
	input  logic [15:0]        current_motor_b,
	input  logic [15:0]        motor_speed,
	input  logic [7:0]         start_byte,
	input  logic [7:0]         end_byte,
	input  logic [2:0]         level_position,
	output logic               push,
	output dlfr_pkg::job_t     push_job
);
	import dlfr_pkg::*;

	logic [3:0]  cnt_q;
	logic [7:0]  fs_q [8];
	logic [15:0] held_a_q;
	logic [15:0] held_b_q;
	logic [15:0] held_s_q;
	logic [15:0] sum;
	logic        sum_ok;
	level_t      lev;

	assign sum = {fs_q[0], fs_q[1]} + {fs_q[2], fs_q[3]} + {fs_q[4], fs_q[5]};
	assign sum_ok = (sum == {fs_q[6], fs_q[7]});
	assign lev = decode_level(fs_q[level_position][3:0]);

	assign push = in_fire && !req_type && (cnt_q == FRAME_LAST) && (rx_byte == end_byte) && sum_ok;
	assign push_job = '{upd: lev.upd, lvl: lev.lvl,
		cur_sum: 17'(mag16(held_a_q) + mag16(held_b_q)), spd_mag: mag16(held_s_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			held_a_q <= '0;
			held_b_q <= '0;
			held_s_q <= '0;
		end else if (in_fire) begin
			if (req_type) begin
				held_a_q <= current_motor_a;
				held_b_q <= current_motor_b;
				held_s_q <= motor_speed;
			end else if (cnt_q == 4'd0) begin
				if (rx_byte == start_byte) cnt_q <= 4'd1;
			end else if (cnt_q < FRAME_LAST) begin
				cnt_q <= cnt_q + 4'd1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && !req_type && cnt_q < FRAME_LAST) begin
			if (cnt_q != 4'd0 || rx_byte == start_byte) fs_q[cnt_q[2:0]] <= rx_byte;
		end
	end

endmodule

// File: hdl/dlfr_queue.sv
// two-entry job queue between front and back
module dlfr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dlfr_pkg::job_t  push_job,
	input  logic            pop,
	output dlfr_pkg::job_t  head,
	output logic            empty,
	output logic            full
);
	import dlfr_pkg::*;

	job_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_job;
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");
`endif

endmodule

// File: hdl/dlfr_div.sv
// shared restoring divider, one quotient bit per cycle
module dlfr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dlfr_pkg::DIV_W-1:0]    dividend,
	input  logic [dlfr_pkg::DIVR_W-1:0]   divisor,
	output logic                          busy,
	output logic                          done,
	output logic [dlfr_pkg::DIV_W-1:0]    quotient
);
	import dlfr_pkg::*;

	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] dvs_q;
	logic [DIV_W-1:0]  quo_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVR_W:0]   trial;
	logic              ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge = (trial >= {1'b0, dvs_q});
	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DIVR_W'(trial - {1'b0, dvs_q}) : trial[DIVR_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

endmodule

// File: hdl/dlfr_back.sv
// back end: reply arithmetic and serialization of the 13-byte reply
module dlfr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  dlfr_pkg::job_t  q_head,
	output logic            pop,
	input  logic [7:0]      start_byte,
	input  logic [7:0]      end_byte,
	input  logic [31:0]     gear_ratio,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,
	output logic            m_tlast,
	output logic [3:0]      m_tuser
);
	import dlfr_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SPD  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DVD  = 3'd3;
	localparam logic [2:0] S_PER  = 3'd4;
	localparam logic [2:0] S_SUM  = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;

	logic [2:0]        state_q;
	job_t              job_q;
	logic [7:0]        cur_q;
	logic [15:0]       period_q;
	logic [15:0]       csum_q;
	logic [3:0]        idx_q;
	logic              div_go_q;
	logic [DIV_W-1:0]  div_a_q;
	logic [DIVR_W-1:0] div_b_q;
	logic [27:0]       spd25_q;
	logic [DIVR_W-1:0] d_q;
	logic              div_busy;
	logic              div_done;
	logic [DIV_W-1:0]  div_q;
	logic              out_v_q;
	logic [7:0]        out_d_q;
	logic              out_l_q;
	logic [3:0]        out_u_q;
	logic              out_free;
	logic              load;
	logic [31:0]       ratio;
	logic [7:0]        num;
	logic [15:0]       den;
	logic [7:0]        rep_byte;
	logic [33:0]       cur_prod;
	logic [56:0]       d_prod;

	dlfr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		ratio = (gear_ratio < RATIO_LOW || gear_ratio > RATIO_HIGH) ? RATIO_LOW : gear_ratio;
		num = ratio[23:16];
		den = ratio[15:0];
		if (den == 16'd0) begin
			num = 8'd1;
			den = 16'd1;
		end
	end

	always_comb begin
		unique case (idx_q)
			4'd0:    rep_byte = start_byte;
			4'd1:    rep_byte = cur_q;
			4'd2:    rep_byte = period_q[7:0];
			4'd3:    rep_byte = period_q[15:8];
			4'd4:    rep_byte = ERR_CODE;
			4'd5:    rep_byte = BRAKE_CODE;
			4'd10:   rep_byte = csum_q[7:0];
			4'd11:   rep_byte = csum_q[15:8];
			4'd12:   rep_byte = end_byte;
			default: rep_byte = 8'h00;
		endcase
	end

	// constant divisions by reciprocal multiplication
	assign cur_prod = q_head.cur_sum * CUR_RECIP;
	assign d_prod   = spd25_q * SPEED_RECIP;

	assign pop      = (state_q == S_IDLE) && !q_empty;
	assign out_free = !out_v_q || m_tready;
	assign load     = (state_q == S_EMIT) && out_free;

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;
	assign m_tlast  = out_l_q;
	assign m_tuser  = out_u_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			div_go_q <= 1'b0;
			out_v_q  <= 1'b0;
			idx_q    <= '0;
		end else begin
			div_go_q <= 1'b0;
			if (load) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (pop) begin
					div_go_q <= 1'b1;
					state_q  <= S_SPD;
				end
				S_SPD: if (div_done) state_q <= S_MUL;
				S_MUL: state_q <= S_DVD;
				S_DVD: begin
					if (d_q == '0) begin
						state_q <= S_SUM;
					end else begin
						div_go_q <= 1'b1;
						state_q  <= S_PER;
					end
				end
				S_PER: if (div_done) state_q <= S_SUM;
				S_SUM: begin
					idx_q   <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: if (out_free) begin
					idx_q <= idx_q + 4'd1;
					if (idx_q == REPLY_LAST) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q   <= q_head;
			cur_q   <= {cur_prod[CUR_SHIFT+6:CUR_SHIFT], 1'b0};
			div_a_q <= DIV_W'(num * q_head.spd_mag);
			div_b_q <= DIVR_W'(den);
		end
		if (state_q == S_SPD && div_done) spd25_q <= 28'(div_q[23:0] * SPEED_MUL);
		if (state_q == S_MUL) d_q <= d_prod[SPEED_SHIFT +: DIVR_W];
		if (state_q == S_DVD) begin
			period_q <= PERIOD_MAX;
			div_a_q  <= PERIOD_NUM;
			div_b_q  <= d_q;
		end
		if (state_q == S_PER && div_done) period_q <= div_q[15:0];
		if (state_q == S_SUM) csum_q <= {cur_q, start_byte} + period_q + {BRAKE_CODE, ERR_CODE};
		if (load) begin
			out_d_q <= rep_byte;
			out_l_q <= (idx_q == REPLY_LAST);
			out_u_q <= (idx_q == 4'd0 && job_q.upd) ? {job_q.lvl, 1'b1} : 4'd0;
		end
	end

`ifndef ASSERT_OFF
	a_start_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> !div_busy)
		else $error("divider started while busy");
	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !div_busy)
		else $error("divider busy while back end idle");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load && idx_q == REPLY_LAST) |=> (state_q == S_IDLE && m_tlast))
		else $error("last reply byte did not end the reply");
`endif

endmodule

// File: hdl/display_link_frame_responder_unit.sv
// top level of the display link frame responder
//  channel  | dir | handshake          | payload
//  s_*      | in  | s_tvalid/s_tready  | tuser: req_type; tdata: rx_byte, current_a/b, speed
//  m_*      | out | m_tvalid/m_tready  | tdata: tx_byte; tlast: last_byte; tuser: update, level
//  cfg_*    | in  | cfg_we             | cfg_addr register index, cfg_data value
// one input transfer per cycle while the two-entry job queue has room
// a valid frame costs up to two divisions then 13 output transfers
// the shared divider in the back end sets the reply latency
// arst_n clears counters, state, held telemetry and registers to their defaults
// output stalls hold the back end; input stalls only when the queue is full
module display_link_frame_responder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [55:0]                   s_tdata,  // rx_byte, current_motor_a, current_motor_b, motor_speed
	input  logic                          s_tuser,  // req_type
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,  // tx_byte
	output logic                          m_tlast,
	output logic [3:0]                    m_tuser,  // level_update, assist_level
	input  logic                          cfg_we,
	input  logic [dlfr_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [dlfr_pkg::CFG_DW-1:0]   cfg_data
);
	import dlfr_pkg::*;

	logic [7:0]  start_q;
	logic [7:0]  end_q;
	logic [2:0]  lpos_q;
	logic [31:0] gear_q;
	logic        in_fire;
	logic        push;
	logic        pop;
	logic        q_empty;
	logic        q_full;
	job_t        push_job;
	job_t        q_head;

	assign s_tready = !q_full;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= RST_START_BYTE;
			end_q   <= RST_END_BYTE;
			lpos_q  <= RST_LEVEL_POS;
			gear_q  <= RATIO_LOW;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_START_BYTE: start_q <= cfg_data[7:0];
				REG_END_BYTE:   end_q   <= cfg_data[7:0];
				REG_LEVEL_POS:  lpos_q  <= cfg_data[2:0];
				REG_GEAR_RATIO: gear_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	dlfr_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_fire         (in_fire),
		.req_type        (s_tuser),
		.rx_byte         (s_tdata[7:0]),
		.current_motor_a (s_tdata[23:8]),
		.current_motor_b (s_tdata[39:24]),
		.motor_speed     (s_tdata[55:40]),
		.start_byte      (start_q),
		.end_byte        (end_q),
		.level_position  (lpos_q),
		.push            (push),
		.push_job        (push_job)
	);

	dlfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	dlfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.pop        (pop),
		.start_byte (start_q),
		.end_byte   (end_q),
		.gear_ratio (gear_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule
